FILE: design/chgd_pkg.sv
// ----------------------------------------------------------------------------
// chgd_pkg: shared types and constants of the greedy change dispenser
// Beat formats, request kinds, status codes and register reset values.
// ----------------------------------------------------------------------------
package chgd_pkg;

   localparam int NUM_DENOMS_DEF  = 8;
   localparam int COUNT_WIDTH_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = 3;
   localparam int VALUE_W   = 16;
   localparam int TYPE_W    = 3;
   localparam int DENOM_W   = 3;
   localparam int CNT_W     = 16;
   localparam int AMT_W     = 16;
   localparam int STAT_W    = 2;

   localparam logic [VALUE_W-1:0] VALUE_RESET [NUM_REGS] =
      '{16'd5, 16'd10, 16'd20, 16'd50, 16'd100, 16'd200, 16'd500, 16'd1000};

   typedef enum logic [TYPE_W-1:0] {
      REQ_ADD      = 3'd0,
      REQ_REMOVE   = 3'd1,
      REQ_CHECK    = 3'd2,
      REQ_DISPENSE = 3'd3,
      REQ_BALANCE  = 3'd4
   } req_kind_type;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_SHORT     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NO_CHANGE = 2'd2;

   typedef struct packed {
      logic [TYPE_W-1:0]  req_type;
      logic [DENOM_W-1:0] denom_index;
      logic [CNT_W-1:0]   coin_count;
      logic [AMT_W-1:0]   amount_cents;
   } req_beat_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [DENOM_W-1:0] out_denom;
      logic [CNT_W-1:0]   out_count;
      logic               last;
   } rsp_beat_type;

   typedef struct packed {
      req_kind_type       kind;
      logic [DENOM_W-1:0] denom;
      logic [CNT_W-1:0]   coin_count;
      logic [AMT_W-1:0]   amount;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_push_type;

endpackage

FILE: design/chgd_front.sv
// ----------------------------------------------------------------------------
// chgd_front: request intake
// Takes request beats, decodes the request type and drops unknown types
// and add/remove/balance beats beyond the configured denomination count.
// ----------------------------------------------------------------------------
module chgd_front #(
   parameter int NUM_DENOMS = chgd_pkg::NUM_DENOMS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  chgd_pkg::req_beat_type   req_beat,
   output chgd_pkg::queue_push_type push,
   input  logic                     queue_full
);
   import chgd_pkg::*;

   localparam logic [DENOM_W:0] NUM_L = (DENOM_W+1)'(NUM_DENOMS);

   logic         accept;
   logic         keep;
   logic         idx_ok;
   req_kind_type kind;
   logic         seen_ff;
   logic         seen_in;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign idx_ok    = {1'b0, req_beat.denom_index} < NUM_L;

   always_comb begin
      kind = REQ_ADD;
      keep = 1'b0;
      case (req_beat.req_type)
         REQ_ADD: begin
            kind = REQ_ADD;
            keep = idx_ok;
         end
         REQ_REMOVE: begin
            kind = REQ_REMOVE;
            keep = idx_ok;
         end
         REQ_BALANCE: begin
            kind = REQ_BALANCE;
            keep = idx_ok;
         end
         REQ_CHECK: begin
            kind = REQ_CHECK;
            keep = 1'b1;
         end
         REQ_DISPENSE: begin
            kind = REQ_DISPENSE;
            keep = 1'b1;
         end
         default: begin
            kind = REQ_ADD;
            keep = 1'b0;
         end
      endcase
   end

   assign push.valid            = accept && keep;
   assign push.entry.kind       = kind;
   assign push.entry.denom      = req_beat.denom_index;
   assign push.entry.coin_count = req_beat.coin_count;
   assign push.entry.amount     = req_beat.amount_cents;

   // track whether any beat has arrived since reset
   assign seen_in = seen_ff || accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !queue_full && seen_in)
      else $error("front pushed into a full queue");

   a_bad_type_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_beat.req_type != REQ_ADD && req_beat.req_type != REQ_REMOVE &&
       req_beat.req_type != REQ_CHECK && req_beat.req_type != REQ_DISPENSE &&
       req_beat.req_type != REQ_BALANCE) |-> !push.valid)
      else $error("unknown request type entered the queue");

   a_bad_index_dropped: assert property (@(posedge clock) disable iff (reset)
      (push.valid && (push.entry.kind == REQ_ADD || push.entry.kind == REQ_REMOVE ||
                      push.entry.kind == REQ_BALANCE)) |-> idx_ok)
      else $error("denomination beyond range entered the queue");

endmodule

FILE: design/chgd_queue.sv
// ----------------------------------------------------------------------------
// chgd_queue: request queue
// Short first-in first-out buffer between intake and execution.
// ----------------------------------------------------------------------------
module chgd_queue #(
   parameter int DEPTH = chgd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  chgd_pkg::queue_push_type  push,
   output logic                      full,
   input  logic                      pop,
   output logic                      empty,
   output chgd_pkg::queue_entry_type head
);
   import chgd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   queue_entry_type  mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full    = fill_ff == CNT_QW'(DEPTH);
   assign empty   = fill_ff == '0;
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_QW'(DEPTH))
      else $error("queue fill count beyond depth");

   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == CNT_QW'(DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with fill count");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |=> fill_ff <= CNT_QW'(1))
      else $error("queue fill moved by more than one from empty");

endmodule

FILE: design/chgd_back.sv
// ----------------------------------------------------------------------------
// chgd_back: request execution
// Holds the coin stock, runs stock updates and the greedy change plan with
// a shared two-bit-per-cycle divider, then emits result and dispense beats.
// ----------------------------------------------------------------------------
module chgd_back #(
   parameter int NUM_DENOMS  = chgd_pkg::NUM_DENOMS_DEF,
   parameter int COUNT_WIDTH = chgd_pkg::COUNT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [chgd_pkg::VALUE_W-1:0]   denom_value [chgd_pkg::NUM_REGS],
   input  logic                           q_empty,
   input  chgd_pkg::queue_entry_type      q_head,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output chgd_pkg::rsp_beat_type         rsp_beat
);
   import chgd_pkg::*;

   localparam int IDX_W  = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
   localparam int SW     = ((COUNT_WIDTH > CNT_W) ? COUNT_WIDTH : CNT_W) + 1;
   localparam int STEPS  = AMT_W / 2;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [IDX_W-1:0]  IDX_TOP   = IDX_W'(NUM_DENOMS - 1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);
   localparam logic [SW-1:0]     STOCK_MAX = SW'({COUNT_WIDTH{1'b1}});

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ONE,
      ST_PLAN,
      ST_DIV,
      ST_MUL,
      ST_SUB,
      ST_FINISH,
      ST_WALK
   } state_type;

   state_type              state_ff, state_in;
   queue_entry_type        ent_ff, ent_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [AMT_W-1:0]       rem_ff, rem_in;
   logic [AMT_W-1:0]       dvd_ff, dvd_in;
   logic [VALUE_W:0]       part_ff, part_in;
   logic [AMT_W-1:0]       quo_ff, quo_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [AMT_W-1:0]       prod_ff, prod_in;
   logic [NUM_DENOMS-1:0]  nz_ff, nz_in;
   logic [AMT_W-1:0]       take_ff [NUM_DENOMS];
   logic [COUNT_WIDTH-1:0] stock_ff [NUM_DENOMS];
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_beat_type           rsp_beat_ff, rsp_beat_in;

   logic                   take_we;
   logic [AMT_W-1:0]       take_wdata;
   logic                   stock_we;
   logic [COUNT_WIDTH-1:0] stock_wdata;

   logic [VALUE_W-1:0]     v;
   logic [COUNT_WIDTH-1:0] stock_rd;
   logic [SW-1:0]          stock_x;
   logic [AMT_W-1:0]       take_rd;
   logic                   out_free;
   logic [NUM_DENOMS-1:0]  below_mask;
   logic [NUM_DENOMS-1:0]  walk_mask;
   logic                   lower_nz;

   assign v        = denom_value[REG_IDX_W'(idx_ff)];
   assign stock_rd = stock_ff[idx_ff];
   assign stock_x  = SW'(stock_rd);
   assign take_rd  = take_ff[idx_ff];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      for (int j = 0; j < NUM_DENOMS; j++) begin
         below_mask[j] = IDX_W'(j) < idx_ff;
         walk_mask[j]  = IDX_W'(j) <= idx_ff;
      end
   end

   assign lower_nz = |(nz_ff & below_mask);

   always_comb begin
      logic [SW-1:0]      cnt_x;
      logic [SW-1:0]      sum_x;
      logic [SW-1:0]      diff_x;
      logic [SW-1:0]      new_x;
      logic [SW-1:0]      n_x;
      logic [VALUE_W:0]   p;
      logic [VALUE_W:0]   t;
      logic [AMT_W-1:0]   d;
      logic [AMT_W-1:0]   q;
      logic [2*AMT_W-1:0] full_prod;

      cnt_x     = SW'(ent_ff.coin_count);
      sum_x     = stock_x + cnt_x;
      diff_x    = stock_x - cnt_x;
      new_x     = stock_x;
      n_x       = '0;
      p         = part_ff;
      d         = dvd_ff;
      q         = quo_ff;
      t         = '0;
      full_prod = '0;

      state_in     = state_ff;
      ent_in       = ent_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      part_in      = part_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      nz_in        = nz_ff;
      take_we      = 1'b0;
      take_wdata   = '0;
      stock_we     = 1'b0;
      stock_wdata  = stock_rd;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_beat_in  = rsp_beat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               ent_in = q_head;
               idx_in = IDX_W'(q_head.denom);
               if (q_head.kind == REQ_CHECK || q_head.kind == REQ_DISPENSE) begin
                  rem_in   = q_head.amount;
                  idx_in   = IDX_TOP;
                  nz_in    = '0;
                  state_in = ST_PLAN;
               end else begin
                  state_in = ST_ONE;
               end
            end
         end
         ST_ONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_beat_in.status    = STAT_OK;
               rsp_beat_in.out_denom = ent_ff.denom;
               rsp_beat_in.last      = 1'b1;
               case (ent_ff.kind)
                  REQ_ADD: begin
                     new_x    = (sum_x > STOCK_MAX) ? STOCK_MAX : sum_x;
                     stock_we = 1'b1;
                  end
                  REQ_REMOVE: begin
                     if (stock_x < cnt_x) begin
                        rsp_beat_in.status = STAT_SHORT;
                     end else begin
                        new_x    = diff_x;
                        stock_we = 1'b1;
                     end
                  end
                  default: begin
                     new_x = stock_x;
                  end
               endcase
               stock_wdata           = new_x[COUNT_WIDTH-1:0];
               rsp_beat_in.out_count = new_x[CNT_W-1:0];
               state_in              = ST_IDLE;
            end
         end
         ST_PLAN: begin
            if (v == '0 || v > rem_ff || stock_rd == '0) begin
               nz_in[idx_ff] = 1'b0;
               if (idx_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end else begin
               part_in  = '0;
               dvd_in   = rem_ff;
               quo_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            for (int j = 0; j < 2; j++) begin
               t = {p[VALUE_W-1:0], d[AMT_W-1]};
               d = {d[AMT_W-2:0], 1'b0};
               if (t >= {1'b0, v}) begin
                  p = t - {1'b0, v};
                  q = {q[AMT_W-2:0], 1'b1};
               end else begin
                  p = t;
                  q = {q[AMT_W-2:0], 1'b0};
               end
            end
            part_in = p;
            dvd_in  = d;
            quo_in  = q;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            n_x           = (SW'(quo_ff) > stock_x) ? stock_x : SW'(quo_ff);
            take_we       = 1'b1;
            take_wdata    = n_x[AMT_W-1:0];
            nz_in[idx_ff] = 1'b1;
            full_prod     = (2*AMT_W)'(n_x[AMT_W-1:0]) * (2*AMT_W)'(v);
            prod_in       = full_prod[AMT_W-1:0];
            state_in      = ST_SUB;
         end
         ST_SUB: begin
            rem_in = rem_ff - prod_ff;
            if (idx_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff - IDX_W'(1);
               state_in = ST_PLAN;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               if (rem_ff != '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_beat_in  = '{status: STAT_NO_CHANGE, out_denom: '0,
                                   out_count: '0, last: 1'b1};
                  state_in     = ST_IDLE;
               end else if (ent_ff.kind == REQ_CHECK || ent_ff.amount == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_beat_in  = '{status: STAT_OK, out_denom: '0,
                                   out_count: '0, last: 1'b1};
                  state_in     = ST_IDLE;
               end else begin
                  idx_in   = IDX_TOP;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (nz_ff[idx_ff]) begin
               if (out_free) begin
                  diff_x       = stock_x - SW'(take_rd);
                  stock_we     = 1'b1;
                  stock_wdata  = diff_x[COUNT_WIDTH-1:0];
                  rsp_valid_in = 1'b1;
                  rsp_beat_in  = '{status: STAT_OK, out_denom: DENOM_W'(idx_ff),
                                   out_count: take_rd, last: !lower_nz};
                  if (!lower_nz) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff - IDX_W'(1);
                  end
               end
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff      <= ent_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      part_ff     <= part_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      nz_ff       <= nz_in;
      rsp_beat_ff <= rsp_beat_in;
      if (take_we) begin
         take_ff[idx_ff] <= take_wdata;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < NUM_DENOMS; j++) begin
            stock_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (stock_we) begin
            stock_ff[idx_ff] <= stock_wdata;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> part_ff < {1'b0, v})
      else $error("partial remainder not below divisor");

   a_sub_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUB |-> prod_ff <= rem_ff)
      else $error("planned coins exceed remainder");

   a_walk_has_coin: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> (nz_ff & walk_mask) != '0)
      else $error("dispense walk with nothing left to emit");

   a_walk_take_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && nz_ff[idx_ff]) |-> SW'(take_rd) <= stock_x)
      else $error("dispense takes more coins than in stock");

endmodule

FILE: design/greedy_change_dispenser.sv
// ----------------------------------------------------------------------------
// greedy_change_dispenser: coin stock keeper with greedy change dispensing
// Intake, request queue and execution unit, plus the denomination value
// registers.
// ----------------------------------------------------------------------------
//  port group   direction  handshake              payload
//  req_         in         req_valid / req_stall  req_beat (req_beat_type)
//  rsp_         out        rsp_valid / rsp_stall  rsp_beat (rsp_beat_type)
//  csr_         in         csr_write_enable       csr_index, csr_write_data
//
//  Add, remove and balance pass through the queue and one update state.
//  Check and dispense walk the denominations one at a time: an unusable
//  one takes only the plan state, a used one the plan, divide, multiply
//  and subtract states (the shared divider gives two quotient bits per
//  step); a dispense then emits up to NUM_DENOMS beats, held by rsp_stall.
//  Reset clears all stock counts and loads the default coin values.
//  The queue keeps taking request beats while the result register is held, until it is full.
// ----------------------------------------------------------------------------
module greedy_change_dispenser #(
   parameter int NUM_DENOMS  = chgd_pkg::NUM_DENOMS_DEF,
   parameter int COUNT_WIDTH = chgd_pkg::COUNT_WIDTH_DEF,
   parameter int QUEUE_DEPTH = chgd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  chgd_pkg::req_beat_type         req_beat,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output chgd_pkg::rsp_beat_type         rsp_beat,
   input  logic                           csr_write_enable,
   input  logic [chgd_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [chgd_pkg::VALUE_W-1:0]   csr_write_data
);
   import chgd_pkg::*;

   logic [VALUE_W-1:0] value_ff [NUM_REGS];
   queue_push_type     push;
   logic               queue_full;
   logic               queue_empty;
   logic               queue_pop;
   queue_entry_type    queue_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_REGS; j++) begin
            value_ff[j] <= VALUE_RESET[j];
         end
      end else if (csr_write_enable) begin
         value_ff[csr_index] <= csr_write_data;
      end
   end

   chgd_front #(
      .NUM_DENOMS (NUM_DENOMS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_beat   (req_beat),
      .push       (push),
      .queue_full (queue_full)
   );

   chgd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (queue_pop),
      .empty (queue_empty),
      .head  (queue_head)
   );

   chgd_back #(
      .NUM_DENOMS  (NUM_DENOMS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .denom_value (value_ff),
      .q_empty     (queue_empty),
      .q_head      (queue_head),
      .q_pop       (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat)
   );

endmodule
